// File: rtl/lcd4_pkg.sv
// Shared types and constants for the 4-bit character display controller.
`default_nettype none

package lcd4_pkg;

    // Width of the timing registers as seen on the configuration port.
    localparam int TIME_W = 17;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PULSE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_NIBBLE_GAP   = 3'd1;
    localparam logic [2:0] CFG_POWERUP_WAIT = 3'd2;
    localparam logic [2:0] CFG_INIT_WAIT    = 3'd3;
    localparam logic [2:0] CFG_SETTLE_WAIT  = 3'd4;
    localparam logic [2:0] CFG_CLEAR_WAIT   = 3'd5;

    // Register reset values.
    localparam logic [7:0]        RST_PULSE_WIDTH  = 8'd1;
    localparam logic [15:0]       RST_NIBBLE_GAP   = 16'd100;
    localparam logic [TIME_W-1:0] RST_POWERUP_WAIT = 17'd45000;
    localparam logic [TIME_W-1:0] RST_INIT_WAIT    = 17'd5000;
    localparam logic [TIME_W-1:0] RST_SETTLE_WAIT  = 17'd100000;
    localparam logic [TIME_W-1:0] RST_CLEAR_WAIT   = 17'd2000;

    // Nibbles of the reset-by-instruction sequence.
    localparam logic [3:0] NIB_INIT_8BIT = 4'h3;
    localparam logic [3:0] NIB_INIT_4BIT = 4'h2;

    // Fixed instruction bytes.
    localparam logic [7:0] INS_FUNCTION_SET = 8'h28;
    localparam logic [7:0] INS_DISPLAY_ON   = 8'h0c;
    localparam logic [7:0] INS_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] INS_CLEAR        = 8'h01;

    // Request codes carried in tuser.
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_INIT      = 3'd1,
        CMD_WRITE_CMD = 3'd2,
        CMD_WRITE_DAT = 3'd3,
        CMD_CURSOR    = 3'd4,
        CMD_CLEAR     = 3'd5
    } t_cmd;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_POWERUP    = 4'd1,
        PH_INIT_PULSE = 4'd2,
        PH_INIT_WAIT  = 4'd3,
        PH_HI_PULSE   = 4'd4,
        PH_HI_GAP     = 4'd5,
        PH_LO_PULSE   = 4'd6,
        PH_LO_GAP     = 4'd7,
        PH_EXTRA      = 4'd8
    } t_phase;

    // Timing configuration as held by the register file.
    typedef struct packed {
        logic [7:0]        pulse_width;
        logic [15:0]       nibble_gap;
        logic [TIME_W-1:0] powerup_wait;
        logic [TIME_W-1:0] init_wait;
        logic [TIME_W-1:0] settle_wait;
        logic [TIME_W-1:0] clear_wait;
    } t_cfg;

    // One result item, first field in the highest bit when packed.
    typedef struct packed {
        logic       accepted;
        logic       busy_res;
        logic [3:0] lcd_nibble;
        logic       lcd_enable;
        logic       lcd_rs;
    } t_result;

    // Instruction bytes sent after the interface is in four-bit mode.
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = INS_FUNCTION_SET;
            2'd1:    v = INS_DISPLAY_ON;
            default: v = INS_ENTRY_MODE;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lcd4_cfg_regs.sv
// Timing configuration register file with a plain write port.
`default_nettype none

module lcd4_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [2:0]                 i_cfg_index,
    input  wire logic [lcd4_pkg::TIME_W-1:0] i_cfg_data,
    output lcd4_pkg::t_cfg                  o_cfg
);
    import lcd4_pkg::*;

    t_cfg r_cfg;

    // Register writes; indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_width  <= RST_PULSE_WIDTH;
            r_cfg.nibble_gap   <= RST_NIBBLE_GAP;
            r_cfg.powerup_wait <= RST_POWERUP_WAIT;
            r_cfg.init_wait    <= RST_INIT_WAIT;
            r_cfg.settle_wait  <= RST_SETTLE_WAIT;
            r_cfg.clear_wait   <= RST_CLEAR_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PULSE_WIDTH:  r_cfg.pulse_width  <= i_cfg_data[7:0];
                CFG_NIBBLE_GAP:   r_cfg.nibble_gap   <= i_cfg_data[15:0];
                CFG_POWERUP_WAIT: r_cfg.powerup_wait <= i_cfg_data;
                CFG_INIT_WAIT:    r_cfg.init_wait    <= i_cfg_data;
                CFG_SETTLE_WAIT:  r_cfg.settle_wait  <= i_cfg_data;
                CFG_CLEAR_WAIT:   r_cfg.clear_wait   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/lcd4_seq.sv
// Phase sequencer: pin state, wait counter and request handling.
`default_nettype none

module lcd4_seq #(
    parameter int COUNTER_WIDTH = 17
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [2:0]   i_cmd,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_row,
    input  wire logic [5:0]   i_col,
    input  wire lcd4_pkg::t_cfg i_cfg,
    output lcd4_pkg::t_result o_result
);
    import lcd4_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam int LW = (CW > TIME_W) ? CW : TIME_W;

    // A zero wait lasts one tick; a wait beyond the counter saturates.
    function automatic logic [CW-1:0] load_count(input logic [TIME_W-1:0] v);
        logic [LW-1:0] ext;
        logic [LW-1:0] cmax;
        ext  = (v == '0) ? LW'(1) : LW'(v);
        cmax = LW'({CW{1'b1}});
        if (ext > cmax) begin
            return {CW{1'b1}};
        end
        return ext[CW-1:0];
    endfunction

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_wait, n_wait;
    logic [1:0]    r_init_repeat, n_init_repeat;
    logic [1:0]    r_init_idx, n_init_idx;
    logic [7:0]    r_byte, n_byte;
    logic          r_rs_latch, n_rs_latch;
    logic          r_extra, n_extra;
    logic          r_in_init, n_in_init;
    logic          r_pin_rs, n_pin_rs;
    logic          r_pin_en, n_pin_en;
    logic [3:0]    r_pin_nib, n_pin_nib;

    logic          acc;
    logic          do_start;
    logic [7:0]    start_val;
    logic          start_rs;

    // State registers, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_wait        <= '0;
            r_init_repeat <= '0;
            r_init_idx    <= '0;
            r_byte        <= '0;
            r_rs_latch    <= 1'b0;
            r_extra       <= 1'b0;
            r_in_init     <= 1'b0;
            r_pin_rs      <= 1'b0;
            r_pin_en      <= 1'b0;
            r_pin_nib     <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_wait        <= n_wait;
            r_init_repeat <= n_init_repeat;
            r_init_idx    <= n_init_idx;
            r_byte        <= n_byte;
            r_rs_latch    <= n_rs_latch;
            r_extra       <= n_extra;
            r_in_init     <= n_in_init;
            r_pin_rs      <= n_pin_rs;
            r_pin_en      <= n_pin_en;
            r_pin_nib     <= n_pin_nib;
        end
    end

    // Next state for one tick or request.
    always_comb begin
        n_phase       = r_phase;
        n_wait        = r_wait;
        n_init_repeat = r_init_repeat;
        n_init_idx    = r_init_idx;
        n_byte        = r_byte;
        n_rs_latch    = r_rs_latch;
        n_extra       = r_extra;
        n_in_init     = r_in_init;
        n_pin_rs      = r_pin_rs;
        n_pin_en      = r_pin_en;
        n_pin_nib     = r_pin_nib;
        acc           = 1'b0;
        do_start      = 1'b0;
        start_val     = '0;
        start_rs      = 1'b0;

        if (i_cmd == CMD_TICK) begin
            // Count the current wait down, and move on when it runs out.
            if (r_phase != PH_IDLE) begin
                if (r_wait > CW'(1)) begin
                    n_wait = r_wait - CW'(1);
                end else begin
                    n_wait = '0;
                    unique case (r_phase)
                        PH_POWERUP: begin
                            n_init_repeat = '0;
                            n_pin_rs      = 1'b0;
                            n_pin_en      = 1'b1;
                            n_pin_nib     = NIB_INIT_8BIT;
                            n_phase       = PH_INIT_PULSE;
                            n_wait        = load_count(TIME_W'(i_cfg.pulse_width));
                        end
                        PH_INIT_PULSE: begin
                            n_pin_en = 1'b0;
                            n_phase  = PH_INIT_WAIT;
                            n_wait   = load_count((r_init_repeat != 2'd3) ?
                                                  i_cfg.init_wait : i_cfg.settle_wait);
                        end
                        PH_INIT_WAIT: begin
                            if (r_init_repeat != 2'd3) begin
                                n_init_repeat = r_init_repeat + 2'd1;
                                n_pin_en      = 1'b1;
                                n_pin_nib     = (r_init_repeat + 2'd1 != 2'd3) ?
                                                NIB_INIT_8BIT : NIB_INIT_4BIT;
                                n_phase       = PH_INIT_PULSE;
                                n_wait        = load_count(TIME_W'(i_cfg.pulse_width));
                            end else begin
                                n_in_init  = 1'b1;
                                n_init_idx = '0;
                                do_start   = 1'b1;
                                start_val  = init_cmd(2'd0);
                            end
                        end
                        PH_HI_PULSE: begin
                            n_pin_en = 1'b0;
                            n_phase  = PH_HI_GAP;
                            n_wait   = load_count(TIME_W'(i_cfg.nibble_gap));
                        end
                        PH_HI_GAP: begin
                            n_pin_en  = 1'b1;
                            n_pin_nib = r_byte[3:0];
                            n_phase   = PH_LO_PULSE;
                            n_wait    = load_count(TIME_W'(i_cfg.pulse_width));
                        end
                        PH_LO_PULSE: begin
                            n_pin_en = 1'b0;
                            n_phase  = PH_LO_GAP;
                            n_wait   = load_count(TIME_W'(i_cfg.nibble_gap));
                        end
                        PH_LO_GAP: begin
                            if (r_extra) begin
                                n_phase = PH_EXTRA;
                                n_wait  = load_count(i_cfg.clear_wait);
                            end else if (r_in_init && r_init_idx < 2'd2) begin
                                n_init_idx = r_init_idx + 2'd1;
                                do_start   = 1'b1;
                                start_val  = init_cmd(r_init_idx + 2'd1);
                            end else begin
                                n_in_init = 1'b0;
                                n_phase   = PH_IDLE;
                                n_wait    = '0;
                            end
                        end
                        default: begin
                            n_extra   = 1'b0;
                            n_in_init = 1'b0;
                            n_phase   = PH_IDLE;
                            n_wait    = '0;
                        end
                    endcase
                end
            end
        end else if (r_phase == PH_IDLE) begin
            // Requests are taken only while idle; unknown codes are ignored.
            unique case (i_cmd)
                CMD_INIT: begin
                    acc           = 1'b1;
                    n_extra       = 1'b0;
                    n_in_init     = 1'b0;
                    n_pin_rs      = 1'b0;
                    n_pin_en      = 1'b0;
                    n_pin_nib     = '0;
                    n_init_repeat = '0;
                    n_init_idx    = '0;
                    n_phase       = PH_POWERUP;
                    n_wait        = load_count(i_cfg.powerup_wait);
                end
                CMD_WRITE_CMD, CMD_WRITE_DAT: begin
                    acc       = 1'b1;
                    n_extra   = 1'b0;
                    n_in_init = 1'b0;
                    do_start  = 1'b1;
                    start_val = i_byte;
                    start_rs  = (i_cmd == CMD_WRITE_DAT);
                end
                CMD_CURSOR: begin
                    acc       = 1'b1;
                    n_extra   = 1'b0;
                    n_in_init = 1'b0;
                    do_start  = 1'b1;
                    start_val = {1'b1, i_row, i_col};
                end
                CMD_CLEAR: begin
                    acc       = 1'b1;
                    n_extra   = (i_cfg.clear_wait != '0);
                    n_in_init = 1'b0;
                    do_start  = 1'b1;
                    start_val = INS_CLEAR;
                end
                default: begin
                end
            endcase
        end

        // Start of a byte transfer: high nibble goes out with enable high.
        if (do_start) begin
            n_byte     = start_val;
            n_rs_latch = start_rs;
            n_pin_rs   = start_rs;
            n_pin_en   = 1'b1;
            n_pin_nib  = start_val[7:4];
            n_phase    = PH_HI_PULSE;
            n_wait     = load_count(TIME_W'(i_cfg.pulse_width));
        end
    end

    // The result shows the pin state after this item.
    always_comb begin
        o_result.lcd_rs     = n_pin_rs;
        o_result.lcd_enable = n_pin_en;
        o_result.lcd_nibble = n_pin_nib;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.accepted   = acc;
    end

endmodule

`default_nettype wire

// File: rtl/char_lcd_nibble_interface.sv
// Usage: character display controller over a 4-bit bus, one item per clock unless stalled.
// Input stream: tuser carries the request code (tick, initialise, command
// byte, data byte, set cursor, clear); tdata carries the byte, row and
// column. Every accepted item yields exactly one result item on the output
// stream giving register select, enable, data nibble, busy and whether the
// request was taken. Timing is counted in tick items, one per microsecond.
// Each result is registered and valid in the cycle after its item is accepted.
// Throughput is one item per cycle, set by the single output
// register; s_axis_tready stays high while that register is empty or being
// drained in the same cycle.
// When the receiver stalls, the held result stays put and input is not
// taken. Requests that arrive while a sequence is running are consumed with
// accepted low. Configuration writes on the plain write port take effect at
// the next edge and should be made while idle.
// Reset (synchronous, active low) returns pins low, the sequencer to idle,
// the timing registers to their defaults and empties the output register.
`default_nettype none

module char_lcd_nibble_interface #(
    parameter int COUNTER_WIDTH = 17
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [15:0]                 s_axis_tdata,  // byte_value, row, col, zero pad
    input  wire logic [2:0]                  s_axis_tuser,  // command
    // Output stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // lcd_rs, lcd_enable,
                                                            // lcd_nibble, busy_res, accepted
    // Configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [lcd4_pkg::TIME_W-1:0] i_cfg_data
);
    import lcd4_pkg::*;

    t_cfg    cfg;
    t_result seq_result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    // The output register is free when empty or being read this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    lcd4_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lcd4_seq #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (s_axis_tuser),
        .i_byte   (s_axis_tdata[7:0]),
        .i_row    (s_axis_tdata[8]),
        .i_col    (s_axis_tdata[14:9]),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= seq_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// File: rtl/lcd4_checker.sv
// Port-level checks for the display controller, bound to the top level.
`default_nettype none

module lcd4_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    // A stalled result holds until taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Every accepted item gives a result in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // No new item is taken while a result is held back.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // A taken request always starts a sequence.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6])
        else $error("accepted request left the controller idle");

    // The enable strobe is high only inside a running sequence.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[6])
        else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface lcd4_checker u_lcd4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking stream testbench for the 4-bit character display controller.
`timescale 1ns / 100ps

module testbench;
    import lcd4_pkg::*;

    localparam int CW          = 17;
    localparam int MAX_IDLE    = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int WORK_TARGET = 175;
    localparam int RAND_PHASES = 4;

    localparam logic [31:0] COUNT_MAX = (32'd1 << CW) - 32'd1;

    // Request codes outside the defined set, and register indexes past the last.
    localparam logic [2:0] CMD_RESERVED_A = 3'd6;
    localparam logic [2:0] CMD_RESERVED_B = 3'd7;
    localparam logic [2:0] CFG_SPARE_A    = 3'd6;
    localparam logic [2:0] CFG_SPARE_B    = 3'd7;

    localparam logic [7:0] BOOT_BYTES [0:2] = '{INS_FUNCTION_SET, INS_DISPLAY_ON,
                                                INS_ENTRY_MODE};

    // One request or tick item as queued for the driver.
    typedef struct packed {
        logic [2:0] code;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
    } t_req;

    // Sequencer state and pin levels of the predictor.
    typedef struct packed {
        t_phase      phase;
        logic [31:0] count;
        logic [1:0]  repeat_n;
        logic [1:0]  cmd_idx;
        logic [7:0]  byte_q;
        logic        rs_q;
        logic        extra;
        logic        in_init;
        logic        pin_rs;
        logic        pin_en;
        logic [3:0]  pin_nib;
    } t_lcd_state;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic [2:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [2:0]            i_cfg_index   = '0;
    logic [TIME_W-1:0]     i_cfg_data    = '0;

    t_cfg       timing;
    t_lcd_state plan_state;
    t_lcd_state pin_state;
    t_req       pending_reqs[$];
    t_result    expected_pins[$];
    t_req       cur_req;
    int         work_items;
    int         pin_errors    = 0;
    int         results_seen  = 0;
    longint     cycles        = 0;
    longint     cycle_budget  = 20000;
    bit         in_taken      = 1'b0;
    int         tx_idle       = 0;
    int         tx_run        = 0;
    bit         tx_quiet      = 1'b0;
    int         rx_hold       = 0;
    int         rx_run        = 0;
    bit         rx_quiet      = 1'b0;
    bit         hold_armed    = 1'b0;
    bit         hold_done     = 1'b0;

    char_lcd_nibble_interface #(.COUNTER_WIDTH(CW)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // A zero wait still lasts one tick; long waits clip to the counter range.
    function automatic logic [31:0] wait_ticks(input logic [31:0] v);
        if (v == 32'd0) return 32'd1;
        if (v > COUNT_MAX) return COUNT_MAX;
        return v;
    endfunction

    function automatic void timing_defaults(inout t_cfg c);
        c.pulse_width  = RST_PULSE_WIDTH;
        c.nibble_gap   = RST_NIBBLE_GAP;
        c.powerup_wait = RST_POWERUP_WAIT;
        c.init_wait    = RST_INIT_WAIT;
        c.settle_wait  = RST_SETTLE_WAIT;
        c.clear_wait   = RST_CLEAR_WAIT;
    endfunction

    function automatic void timing_write(inout t_cfg c, input logic [2:0] idx,
                                         input logic [TIME_W-1:0] v);
        unique case (idx)
            CFG_PULSE_WIDTH:  c.pulse_width  = v[7:0];
            CFG_NIBBLE_GAP:   c.nibble_gap   = v[15:0];
            CFG_POWERUP_WAIT: c.powerup_wait = v;
            CFG_INIT_WAIT:    c.init_wait    = v;
            CFG_SETTLE_WAIT:  c.settle_wait  = v;
            CFG_CLEAR_WAIT:   c.clear_wait   = v;
            default: ;
        endcase
    endfunction

    // Start a byte transfer with the high nibble on the pins.
    function automatic void begin_byte(inout t_lcd_state s, input t_cfg c,
                                       input logic [7:0] v, input logic rs);
        s.byte_q  = v;
        s.rs_q    = rs;
        s.pin_rs  = rs;
        s.pin_en  = 1'b1;
        s.pin_nib = v[7:4];
        s.phase   = PH_HI_PULSE;
        s.count   = wait_ticks(32'(c.pulse_width));
    endfunction

    // Move on once the current phase's wait has run out.
    function automatic void next_phase(inout t_lcd_state s, input t_cfg c);
        unique case (s.phase)
            PH_POWERUP: begin
                s.repeat_n = 2'd0;
                s.pin_rs   = 1'b0;
                s.pin_en   = 1'b1;
                s.pin_nib  = NIB_INIT_8BIT;
                s.phase    = PH_INIT_PULSE;
                s.count    = wait_ticks(32'(c.pulse_width));
            end
            PH_INIT_PULSE: begin
                s.pin_en = 1'b0;
                s.phase  = PH_INIT_WAIT;
                s.count  = wait_ticks(s.repeat_n < 2'd3 ? 32'(c.init_wait)
                                                        : 32'(c.settle_wait));
            end
            PH_INIT_WAIT: begin
                if (s.repeat_n < 2'd3) begin
                    s.repeat_n = s.repeat_n + 2'd1;
                    s.pin_en   = 1'b1;
                    s.pin_nib  = (s.repeat_n < 2'd3) ? NIB_INIT_8BIT : NIB_INIT_4BIT;
                    s.phase    = PH_INIT_PULSE;
                    s.count    = wait_ticks(32'(c.pulse_width));
                end else begin
                    s.in_init = 1'b1;
                    s.cmd_idx = 2'd0;
                    begin_byte(s, c, BOOT_BYTES[0], 1'b0);
                end
            end
            PH_HI_PULSE: begin
                s.pin_en = 1'b0;
                s.phase  = PH_HI_GAP;
                s.count  = wait_ticks(32'(c.nibble_gap));
            end
            PH_HI_GAP: begin
                s.pin_en  = 1'b1;
                s.pin_nib = s.byte_q[3:0];
                s.phase   = PH_LO_PULSE;
                s.count   = wait_ticks(32'(c.pulse_width));
            end
            PH_LO_PULSE: begin
                s.pin_en = 1'b0;
                s.phase  = PH_LO_GAP;
                s.count  = wait_ticks(32'(c.nibble_gap));
            end
            PH_LO_GAP: begin
                if (s.extra) begin
                    s.phase = PH_EXTRA;
                    s.count = wait_ticks(32'(c.clear_wait));
                end else if (s.in_init && s.cmd_idx < 2'd2) begin
                    s.cmd_idx = s.cmd_idx + 2'd1;
                    begin_byte(s, c, BOOT_BYTES[s.cmd_idx], 1'b0);
                end else begin
                    s.in_init = 1'b0;
                    s.phase   = PH_IDLE;
                    s.count   = '0;
                end
            end
            default: begin
                s.extra   = 1'b0;
                s.in_init = 1'b0;
                s.phase   = PH_IDLE;
                s.count   = '0;
            end
        endcase
    endfunction

    // Pin state after one item; requests are taken only while idle.
    function automatic t_result lcd_pin_step(inout t_lcd_state s, input t_cfg c,
                                             input t_req q);
        t_result r;
        logic    taken;
        taken = 1'b0;
        if (q.code == CMD_TICK) begin
            if (s.phase != PH_IDLE) begin
                if (s.count > 32'd1) begin
                    s.count = s.count - 32'd1;
                end else begin
                    s.count = '0;
                    next_phase(s, c);
                end
            end
        end else if (q.code <= CMD_CLEAR && s.phase == PH_IDLE) begin
            taken     = 1'b1;
            s.extra   = 1'b0;
            s.in_init = 1'b0;
            unique case (q.code)
                CMD_INIT: begin
                    s.pin_rs   = 1'b0;
                    s.pin_en   = 1'b0;
                    s.pin_nib  = 4'h0;
                    s.repeat_n = 2'd0;
                    s.cmd_idx  = 2'd0;
                    s.phase    = PH_POWERUP;
                    s.count    = wait_ticks(32'(c.powerup_wait));
                end
                CMD_WRITE_CMD: begin_byte(s, c, q.value, 1'b0);
                CMD_WRITE_DAT: begin_byte(s, c, q.value, 1'b1);
                CMD_CURSOR:    begin_byte(s, c, {1'b1, q.row, q.col}, 1'b0);
                default: begin
                    s.extra = (c.clear_wait != '0);
                    begin_byte(s, c, INS_CLEAR, 1'b0);
                end
            endcase
        end
        r.lcd_rs     = s.pin_rs;
        r.lcd_enable = s.pin_en;
        r.lcd_nibble = s.pin_nib;
        r.busy_res   = (s.phase != PH_IDLE);
        r.accepted   = taken;
        return r;
    endfunction

    // Idle length for either side: quiet stretches, mostly short gaps, a few long.
    function automatic int idle_len(inout int run_left, inout bit quiet);
        int r;
        if (run_left == 0) begin
            quiet    = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(20, 150);
        end
        run_left--;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, MAX_IDLE);
    endfunction

    // Queue an item and advance the planning copy so the stimulus knows the phase.
    function automatic void add_req(input logic [2:0] code);
        t_req    q;
        t_result r;
        logic    was_busy;
        q.code   = code;
        q.value  = 8'($urandom);
        q.row    = 1'($urandom);
        q.col    = 6'($urandom);
        was_busy = (plan_state.phase != PH_IDLE);
        r = lcd_pin_step(plan_state, timing, q);
        if (r.accepted || (code == CMD_TICK && was_busy)) work_items++;
        pending_reqs.push_back(q);
        cycle_budget += 4 * (2 * MAX_IDLE + 4);
    endfunction

    // Queue a request with chosen content.
    function automatic void add_fixed(input logic [2:0] code, input logic [7:0] value,
                                      input logic row, input logic [5:0] col);
        t_req    q;
        t_result r;
        q.code  = code;
        q.value = value;
        q.row   = row;
        q.col   = col;
        r = lcd_pin_step(plan_state, timing, q);
        work_items++;
        pending_reqs.push_back(q);
        cycle_budget += 4 * (2 * MAX_IDLE + 4);
    endfunction

    // Tick until the planned sequence has finished.
    function automatic void tick_to_idle();
        while (plan_state.phase != PH_IDLE) add_req(CMD_TICK);
    endfunction

    function automatic logic [2:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CMD_INIT;
        if (r < 35) return CMD_WRITE_CMD;
        if (r < 65) return CMD_WRITE_DAT;
        if (r < 85) return CMD_CURSOR;
        return CMD_CLEAR;
    endfunction

    task automatic report_error(input string msg);
        if (pin_errors < 100) $display("ERROR result %0d: %s", results_seen, msg);
        pin_errors++;
    endtask

    // One register write on the configuration port, mirrored in the predictor.
    task automatic write_reg(input logic [2:0] idx, input logic [TIME_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        timing_write(timing, idx, v);
    endtask

    // Wait until every queued item is through and its result has been checked.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pins.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Predict at each accepted input item.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_pins.push_back(lcd_pin_step(pin_state, timing, cur_req));
            in_taken = 1'b1;
        end
    end

    // Input driver: next item after acceptance, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (tx_idle > 0) begin
                tx_idle--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                s_axis_tdata  <= {1'b0, cur_req.col, cur_req.row, cur_req.value};
                s_axis_tuser  <= cur_req.code;
                s_axis_tvalid <= 1'b1;
                tx_idle = idle_len(tx_run, tx_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off once armed.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rx_hold   = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_hold = idle_len(rx_run, rx_quiet);
            if (rx_hold == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (expected_pins.size() == 0) begin
                report_error($sformatf("unexpected result %02h", m_axis_tdata));
            end else begin
                want = expected_pins.pop_front();
                if (got.lcd_rs !== want.lcd_rs)
                    report_error($sformatf("lcd_rs exp %b got %b", want.lcd_rs, got.lcd_rs));
                if (got.lcd_enable !== want.lcd_enable)
                    report_error($sformatf("lcd_enable exp %b got %b",
                                           want.lcd_enable, got.lcd_enable));
                if (got.lcd_nibble !== want.lcd_nibble)
                    report_error($sformatf("lcd_nibble exp %h got %h",
                                           want.lcd_nibble, got.lcd_nibble));
                if (got.busy_res !== want.busy_res)
                    report_error($sformatf("busy_res exp %b got %b",
                                           want.busy_res, got.busy_res));
                if (got.accepted !== want.accepted)
                    report_error($sformatf("accepted exp %b got %b",
                                           want.accepted, got.accepted));
            end
            results_seen++;
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > cycle_budget) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus: directed phases under fixed timings, then random phases.
    initial begin
        int r;
        int p;
        timing_defaults(timing);
        plan_state = '0;
        pin_state  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timings: idle tick, reserved codes, one byte at default speed.
        add_req(CMD_TICK);
        add_req(CMD_RESERVED_A);
        add_req(CMD_RESERVED_B);
        add_fixed(CMD_WRITE_DAT, 8'h96, 1'b0, 6'd0);
        tick_to_idle();
        drain();

        // All timings zero, so every wait lasts one tick and clear skips its wait.
        write_reg(CFG_PULSE_WIDTH, '0);
        write_reg(CFG_NIBBLE_GAP, '0);
        write_reg(CFG_POWERUP_WAIT, '0);
        write_reg(CFG_INIT_WAIT, '0);
        write_reg(CFG_SETTLE_WAIT, '0);
        write_reg(CFG_CLEAR_WAIT, '0);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        add_fixed(CMD_WRITE_DAT, 8'hA5, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_INIT, 8'h00, 1'b0, 6'd0);
        add_fixed(CMD_WRITE_DAT, 8'h11, 1'b1, 6'd5);
        add_fixed(CMD_CLEAR, 8'h22, 1'b0, 6'd9);
        add_req(CMD_TICK);
        add_fixed(CMD_CURSOR, 8'h33, 1'b1, 6'd63);
        tick_to_idle();
        add_fixed(CMD_WRITE_CMD, 8'hFF, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_WRITE_CMD, 8'h00, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_WRITE_DAT, 8'h5A, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_CURSOR, 8'h00, 1'b1, 6'd63);
        tick_to_idle();
        add_fixed(CMD_CURSOR, 8'hFF, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_CLEAR, 8'h00, 1'b0, 6'd0);
        tick_to_idle();
        drain();

        // Multi-tick pulse and power-up wait; upper data bits of the pulse write dropped.
        write_reg(CFG_PULSE_WIDTH, 17'h1FF03);
        write_reg(CFG_NIBBLE_GAP, 17'd1);
        write_reg(CFG_POWERUP_WAIT, 17'd40);
        write_reg(CFG_INIT_WAIT, 17'd1);
        write_reg(CFG_SETTLE_WAIT, 17'd1);
        write_reg(CFG_CLEAR_WAIT, 17'd3);
        add_fixed(CMD_INIT, 8'h00, 1'b0, 6'd0);
        add_fixed(CMD_WRITE_CMD, 8'h44, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_CLEAR, 8'h00, 1'b0, 6'd0);
        tick_to_idle();
        drain();

        // Longer nibble gap with its top data bit dropped, then a clear with a long wait.
        write_reg(CFG_PULSE_WIDTH, 17'd1);
        write_reg(CFG_NIBBLE_GAP, 17'h1000A);
        write_reg(CFG_CLEAR_WAIT, 17'd20);
        add_fixed(CMD_WRITE_DAT, 8'hC3, 1'b0, 6'd0);
        tick_to_idle();
        add_fixed(CMD_CLEAR, 8'h00, 1'b0, 6'd0);
        tick_to_idle();
        drain();

        // Random phases: small random timings, mostly well-formed sequences.
        for (p = 0; p < RAND_PHASES; p++) begin
            write_reg(CFG_PULSE_WIDTH, {9'($urandom), 8'($urandom_range(0, 4))});
            write_reg(CFG_NIBBLE_GAP, {1'($urandom), 16'($urandom_range(0, 8))});
            write_reg(CFG_POWERUP_WAIT, 17'($urandom_range(0, 30)));
            write_reg(CFG_INIT_WAIT, 17'($urandom_range(0, 10)));
            write_reg(CFG_SETTLE_WAIT, 17'($urandom_range(0, 30)));
            write_reg(CFG_CLEAR_WAIT,
                      ($urandom_range(0, 2) == 0) ? '0 : 17'($urandom_range(1, 12)));
            work_items = 0;
            while (work_items < WORK_TARGET) begin
                r = $urandom_range(0, 99);
                if (plan_state.phase == PH_IDLE) begin
                    if (r < 6) add_req(CMD_TICK);
                    else if (r < 10) add_req(r[0] ? CMD_RESERVED_A : CMD_RESERVED_B);
                    else add_req(pick_request());
                end else begin
                    if (r < 90) add_req(CMD_TICK);
                    else if (r < 97) add_req(pick_request());
                    else add_req(r[0] ? CMD_RESERVED_A : CMD_RESERVED_B);
                end
            end
            tick_to_idle();
            if (p == 0) begin
                cycle_budget += HOLD_CYCLES;
                hold_armed = 1'b1;
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (pin_errors == 0 && expected_pins.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
